// ===== hw/rtl/cdf_lower_bound_sampler_macros.svh =====
// Assertion helpers for the sampler checker.
`ifndef CDF_LOWER_BOUND_SAMPLER_MACROS_SVH
`define CDF_LOWER_BOUND_SAMPLER_MACROS_SVH

// same-cycle implication
`define CLBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clbs assertion failed");

// next-cycle implication
`define CLBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clbs assertion failed");

`endif

// ===== hw/rtl/clbs_pkg.sv =====
package clbs_pkg;

  localparam int MaxEntries   = 256;
  localparam int FractionBits = 16;

  localparam int ValW   = FractionBits + 1;          // Q1.16 word
  localparam int AddrW  = $clog2(MaxEntries);        // table address
  localparam int CntW   = $clog2(MaxEntries + 1);    // search count / first
  localparam int IdxFw  = 8;                         // entry_index field
  localparam int CfgW   = 9;                         // entries_in_use register
  localparam int ResW   = 9;                         // spike_index field

  localparam logic [CfgW-1:0] CfgReset = CfgW'(256);

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdDraw = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;   // write table entry
    logic start;  // latch draw value, issue first probe
    logic step;   // compare probe, issue next
    logic emit;   // load result into output register
  } clbs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;  // clamped count is zero
    logic last;   // current step finishes the search
  } clbs_sts_t;

endpackage

// ===== hw/rtl/cdf_lower_bound_sampler.sv =====
// channel   direction  handshake                 word
// cfg       in         cfg_we_i                  cfg_wdata_i (entries_in_use)
// in        in         in_valid_i / in_stall_o   command_i, entry_index_i, value_i
// out       out        out_valid_o / out_stall_i spike_index_o
//
// A load leaves in_stall_o low. A draw keeps in_stall_o high through the search
// and hold states, n = min(entries_in_use, 256) (search skipped when n is zero):
// one probe per cycle through the table RAM's registered read port, then the
// output register is loaded once it is free.
// Reset clears control and sets entries_in_use to 256; table contents are
// undefined until written. A finished draw waits in the controller while the
// output register is stalled; no new word is taken until it moves.
module cdf_lower_bound_sampler import clbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             command_i,
  input  logic [IdxFw-1:0] entry_index_i,
  input  logic [ValW-1:0]  value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [ResW-1:0]  spike_index_o
);

  clbs_cmd_t cmd;
  clbs_sts_t sts;

  clbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  clbs_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .entry_index_i (entry_index_i),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .spike_index_o (spike_index_o)
  );

endmodule

// ===== hw/rtl/clbs_dpath.sv =====
module clbs_dpath import clbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CfgW-1:0]  cfg_wdata_i,
  input  logic [IdxFw-1:0] entry_index_i,
  input  logic [ValW-1:0]  value_i,
  input  clbs_cmd_t        cmd_i,
  output clbs_sts_t        sts_o,
  output logic [ResW-1:0]  spike_index_o
);

  logic [ValW-1:0]  mem [MaxEntries];
  logic [ValW-1:0]  rdata_q;
  logic [AddrW-1:0] rd_addr;

  logic [CfgW-1:0]  cfg_q;
  logic [CntW-1:0]  n_clamp;

  logic [CntW-1:0]  first_q, first_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [ValW-1:0]  val_q;
  logic [ResW-1:0]  out_q;

  logic [CntW-1:0]  half;
  logic [CntW-1:0]  probe;
  logic             less;
  logic [CntW-1:0]  step_first;
  logic [CntW-1:0]  step_count;
  logic             load_ok;

  assign n_clamp = (32'(cfg_q) > MaxEntries) ? CntW'(MaxEntries) : CntW'(cfg_q);
  assign load_ok = 32'(entry_index_i) < MaxEntries;

  // one probe per cycle: compare the word read last cycle, then address the next
  assign half       = count_q >> 1;
  assign probe      = first_q + half;
  assign less       = rdata_q < val_q;
  assign step_first = less ? probe + CntW'(1) : first_q;
  assign step_count = less ? count_q - half - CntW'(1) : half;

  always_comb begin
    first_d = first_q;
    count_d = count_q;
    rd_addr = AddrW'(step_first + (step_count >> 1));
    if (cmd_i.start) begin
      first_d = '0;
      count_d = n_clamp;
      rd_addr = AddrW'(n_clamp >> 1);
    end else if (cmd_i.step) begin
      first_d = step_first;
      count_d = step_count;
    end
  end

  assign sts_o.empty = (n_clamp == '0);
  assign sts_o.last  = (step_count == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && load_ok) begin
      mem[AddrW'(entry_index_i)] <= value_i;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    count_q <= count_d;
    if (cmd_i.start) begin
      val_q <= value_i;
    end
    if (cmd_i.emit) begin
      out_q <= ResW'(first_q);
    end
  end

  assign spike_index_o = out_q;

endmodule

// ===== hw/rtl/clbs_ctrl.sv =====
module clbs_ctrl import clbs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      command_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  clbs_sts_t sts_i,
  output clbs_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StHold
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_fire;
  logic   slot_free;

  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (command_i == CmdDraw) begin
            cmd_o.start = 1'b1;
            // nothing to search: first stays zero
            state_d = sts_i.empty ? StHold : StSearch;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      StSearch: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (slot_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/clbs_checker.sv =====
`include "cdf_lower_bound_sampler_macros.svh"

module clbs_checker import clbs_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic [CfgW-1:0]  cfg_wdata_i,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             command_i,
  input logic [IdxFw-1:0] entry_index_i,
  input logic [ValW-1:0]  value_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [ResW-1:0]  spike_index_o
);

  logic in_acc;
  logic draw_acc;
  logic load_acc;
  logic unused_ok;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign draw_acc  = in_acc && (command_i == CmdDraw);
  assign load_acc  = in_acc && (command_i == CmdLoad);
  assign unused_ok = cfg_we_i ^ (^cfg_wdata_i) ^ (^entry_index_i) ^ (^value_i);

  // a draw holds off the next word while it searches
  `CLBS_ASSERT_NXT(a_draw_stalls, clk_i, rst_ni, draw_acc, in_stall_o)

  // no result can show up the cycle after a draw is taken
  `CLBS_ASSERT_NXT(a_no_instant_result, clk_i, rst_ni, draw_acc, !$rose(out_valid_o))

  // a load never creates an output word
  `CLBS_ASSERT_NXT(a_load_silent, clk_i, rst_ni, load_acc && !out_valid_o, !out_valid_o)

  // stalled result word holds
  `CLBS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(spike_index_o))

endmodule

bind cdf_lower_bound_sampler clbs_checker u_clbs_checker (.*);
